// ===== rtl/cdq_pkg.sv =====
`timescale 1ns / 1ps

package cdq_pkg;

  // operation codes of an input transaction
  typedef enum logic [1:0] {
    OP_PUSH_REAR  = 2'd0,
    OP_PUSH_FRONT = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_REAR   = 2'd3
  } op_e;

  // status codes of a result transaction
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_FULL       = 2'd1,
    ST_EMPTY      = 2'd2
  } status_e;

  // command applied to every cell of one chain; near is the anchored end
  typedef enum logic [2:0] {
    CMD_HOLD      = 3'd0,
    CMD_PUSH_NEAR = 3'd1,
    CMD_PUSH_FAR  = 3'd2,
    CMD_POP_NEAR  = 3'd3,
    CMD_POP_FAR   = 3'd4
  } cmd_e;

  // control group from the top level to one chain
  typedef struct packed {
    cmd_e cmd;
  } chain_ctrl_t;

  localparam int unsigned ValueWidth = 8;
  localparam int unsigned CountWidth = 5;

  typedef struct packed {
    op_e                   operation;
    logic [ValueWidth-1:0] value;
  } in_t;

  typedef struct packed {
    logic [ValueWidth-1:0] data_out;
    status_e               status;
    logic [CountWidth-1:0] item_count;
    logic                  is_empty;
    logic                  is_full;
  } out_t;

endpackage

// ===== rtl/cdq_cell.sv =====
`timescale 1ns / 1ps

module cdq_cell #(
  parameter int unsigned DATA_WIDTH = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cdq_pkg::chain_ctrl_t  ctrl_i,
  input  logic [DATA_WIDTH-1:0] push_data_i,
  input  logic [DATA_WIDTH-1:0] inner_data_i,
  input  logic                  inner_valid_i,
  input  logic [DATA_WIDTH-1:0] outer_data_i,
  input  logic                  outer_valid_i,
  output logic [DATA_WIDTH-1:0] data_o,
  output logic                  valid_o
);

  logic [DATA_WIDTH-1:0] data_q, data_d;
  logic                  valid_q, valid_d;

  // local decision from the two neighbors
  always_comb begin
    data_d  = data_q;
    valid_d = valid_q;
    case (ctrl_i.cmd)
      cdq_pkg::CMD_PUSH_NEAR: begin
        data_d  = inner_data_i;
        valid_d = inner_valid_i;
      end
      cdq_pkg::CMD_PUSH_FAR: begin
        // first free slot past the occupied run takes the value
        if (!valid_q && inner_valid_i) begin
          data_d  = push_data_i;
          valid_d = 1'b1;
        end
      end
      cdq_pkg::CMD_POP_NEAR: begin
        data_d  = outer_data_i;
        valid_d = outer_valid_i;
      end
      cdq_pkg::CMD_POP_FAR: begin
        // last occupied slot drops out
        if (valid_q && !outer_valid_i) begin
          valid_d = 1'b0;
        end
      end
      default: begin
        data_d  = data_q;
        valid_d = valid_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o  = data_q;
  assign valid_o = valid_q;

endmodule

// ===== rtl/cdq_chain.sv =====
`timescale 1ns / 1ps

module cdq_chain #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cdq_pkg::chain_ctrl_t  ctrl_i,
  input  logic [DATA_WIDTH-1:0] push_data_i,
  output logic [DATA_WIDTH-1:0] near_data_o,
  output logic                  near_valid_o
);

  logic [DATA_WIDTH-1:0] cell_data  [DEPTH];
  logic                  cell_valid [DEPTH];

  // row of cells, entries packed against the anchored end
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] inner_data;
    logic                  inner_valid;
    logic [DATA_WIDTH-1:0] outer_data;
    logic                  outer_valid;

    if (i == 0) begin : g_first
      assign inner_data  = push_data_i;
      assign inner_valid = 1'b1;
    end else begin : g_mid
      assign inner_data  = cell_data[i-1];
      assign inner_valid = cell_valid[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign outer_data  = '0;
      assign outer_valid = 1'b0;
    end else begin : g_rest
      assign outer_data  = cell_data[i+1];
      assign outer_valid = cell_valid[i+1];
    end

    cdq_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl_i),
      .push_data_i  (push_data_i),
      .inner_data_i (inner_data),
      .inner_valid_i(inner_valid),
      .outer_data_i (outer_data),
      .outer_valid_i(outer_valid),
      .data_o       (cell_data[i]),
      .valid_o      (cell_valid[i])
    );
  end

  assign near_data_o  = cell_data[0];
  assign near_valid_o = cell_valid[0];

endmodule

// ===== rtl/circular_deque.sv =====
`timescale 1ns / 1ps

// Double-ended queue of DEPTH entries of DATA_WIDTH bits. Each input transaction
// pushes at the rear or front, or pops from the front or rear, and yields one
// result transaction with the popped value, a status code and the occupancy
// after the operation. A push onto a full queue and a pop from an empty one
// change nothing and report their status. One transaction is taken per clock
// cycle; its result appears in the output register on the next cycle, and a
// new transaction is taken while that result waits as long as the output side
// does not stall. Storage is two rows of cells, one packed against the front
// and one against the rear, so both ends sit at fixed cells and every update is
// a shift or neighbor-local write.
module circular_deque #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  cdq_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output cdq_pkg::out_t out_data_o
);

  localparam int unsigned CntWidth = $clog2(DEPTH + 1);

  logic                  accept;
  logic [CntWidth-1:0]   count_q, count_d;
  logic                  full;
  logic                  nonempty;
  logic [DATA_WIDTH-1:0] push_value;
  logic [DATA_WIDTH-1:0] front_data, rear_data;
  logic                  front_valid, rear_valid;
  cdq_pkg::chain_ctrl_t  front_ctrl, rear_ctrl;
  logic [DATA_WIDTH-1:0] pop_data;
  cdq_pkg::status_e      status;
  logic                  out_valid_q, out_valid_d;
  cdq_pkg::out_t         out_q, out_d;

  // handshake, output register parts the two sides
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign push_value = DATA_WIDTH'(in_data_i.value);
  assign full       = (count_q == CntWidth'(DEPTH));
  assign nonempty   = front_valid && rear_valid;

  // decode the operation into commands for both rows
  always_comb begin
    front_ctrl.cmd = cdq_pkg::CMD_HOLD;
    rear_ctrl.cmd  = cdq_pkg::CMD_HOLD;
    count_d        = count_q;
    pop_data       = '0;
    status         = cdq_pkg::ST_OK;
    case (in_data_i.operation)
      cdq_pkg::OP_PUSH_REAR: begin
        if (full) begin
          status = cdq_pkg::ST_FULL;
        end else begin
          front_ctrl.cmd = cdq_pkg::CMD_PUSH_FAR;
          rear_ctrl.cmd  = cdq_pkg::CMD_PUSH_NEAR;
          count_d        = count_q + CntWidth'(1);
        end
      end
      cdq_pkg::OP_PUSH_FRONT: begin
        if (full) begin
          status = cdq_pkg::ST_FULL;
        end else begin
          front_ctrl.cmd = cdq_pkg::CMD_PUSH_NEAR;
          rear_ctrl.cmd  = cdq_pkg::CMD_PUSH_FAR;
          count_d        = count_q + CntWidth'(1);
        end
      end
      cdq_pkg::OP_POP_FRONT: begin
        if (!nonempty) begin
          status = cdq_pkg::ST_EMPTY;
        end else begin
          front_ctrl.cmd = cdq_pkg::CMD_POP_NEAR;
          rear_ctrl.cmd  = cdq_pkg::CMD_POP_FAR;
          count_d        = count_q - CntWidth'(1);
          pop_data       = front_data;
        end
      end
      cdq_pkg::OP_POP_REAR: begin
        if (!nonempty) begin
          status = cdq_pkg::ST_EMPTY;
        end else begin
          front_ctrl.cmd = cdq_pkg::CMD_POP_FAR;
          rear_ctrl.cmd  = cdq_pkg::CMD_POP_NEAR;
          count_d        = count_q - CntWidth'(1);
          pop_data       = rear_data;
        end
      end
      default: begin
        status = cdq_pkg::ST_OK;
      end
    endcase
    if (!accept) begin
      front_ctrl.cmd = cdq_pkg::CMD_HOLD;
      rear_ctrl.cmd  = cdq_pkg::CMD_HOLD;
      count_d        = count_q;
    end
  end

  // row anchored at the front
  cdq_chain #(
    .DEPTH     (DEPTH),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_front_chain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (front_ctrl),
    .push_data_i (push_value),
    .near_data_o (front_data),
    .near_valid_o(front_valid)
  );

  // row anchored at the rear
  cdq_chain #(
    .DEPTH     (DEPTH),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_rear_chain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (rear_ctrl),
    .push_data_i (push_value),
    .near_data_o (rear_data),
    .near_valid_o(rear_valid)
  );

  // result transaction
  always_comb begin
    out_d.data_out   = cdq_pkg::ValueWidth'(pop_data);
    out_d.status     = status;
    out_d.item_count = cdq_pkg::CountWidth'(count_d);
    out_d.is_empty   = (count_d == '0);
    out_d.is_full    = (count_d == CntWidth'(DEPTH));
  end

  assign out_valid_d = accept || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // both rows agree with the count on occupancy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (front_valid == (count_q != '0)) && (rear_valid == (count_q != '0)))
    else $error("cell rows disagree with entry count");

  // an accepted push that is not rejected grows the count by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !full && (in_data_i.operation == cdq_pkg::OP_PUSH_REAR ||
                         in_data_i.operation == cdq_pkg::OP_PUSH_FRONT))
    |=> (count_q == $past(count_q) + CntWidth'(1)))
    else $error("push did not advance entry count");

  // a rejected transaction leaves the count unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && status != cdq_pkg::ST_OK) |=> $stable(count_q))
    else $error("rejected transaction changed entry count");
`endif

endmodule
